@@ rtl/prbe_pkg.sv @@
`timescale 1ns / 1ps

package prbe_pkg;

    // Buffer geometry
    localparam int SLOTS           = 8;
    localparam int PRIORITY_LEVELS = 8;
    localparam int SLOT_BITS       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int COUNT_BITS      = $clog2(SLOTS + 1);

    // Field widths fixed by the interface
    localparam int PRI_BITS = 3;
    localparam int ID_BITS  = 16;

    // Request kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_TAKE   = 1'b1;

    typedef logic [SLOT_BITS-1:0]  t_slot;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [PRI_BITS-1:0]   t_pri;
    typedef logic [ID_BITS-1:0]    t_id;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_TAKE_SCAN,
        ST_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic start;      // capture item, set up scan
        logic ins_step;   // occupied slot seen, move to next
        logic ins_evict;  // every slot occupied, evict at pointer
        logic take_step;  // compare slot, move to next
        logic commit;     // update state, load result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic kind;       // kind of the item in flight
        logic slot_free;  // slot under scan is unoccupied
        logic last;       // scan is at its final slot
        logic out_busy;   // result register still holds an item
    } t_status;

    // Next slot with wrap
    function automatic t_slot next_slot(input t_slot s);
        return (s == t_slot'(SLOTS - 1)) ? '0 : s + t_slot'(1);
    endfunction

endpackage

@@ rtl/prbe_ctrl.sv @@
`timescale 1ns / 1ps

module prbe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_ready,
    input  prbe_pkg::t_status i_status,
    output prbe_pkg::t_cmd   o_cmd
);
    import prbe_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_INS_SCAN;
                end
            end
            ST_INS_SCAN: begin
                if (i_status.kind == KIND_TAKE) begin
                    n_state = ST_TAKE_SCAN;
                end else if (i_status.slot_free) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.ins_step = 1'b1;
                    if (i_status.last) begin
                        // wrapped back to pointer: full
                        o_cmd.ins_evict = 1'b1;
                        n_state         = ST_FINISH;
                    end
                end
            end
            ST_TAKE_SCAN: begin
                o_cmd.take_step = 1'b1;
                if (i_status.last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait for room in the result register
                if (!i_status.out_busy || i_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/prbe_dp.sv @@
`timescale 1ns / 1ps

module prbe_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prbe_pkg::t_cmd    i_cmd,
    output prbe_pkg::t_status o_status,
    input  logic              i_kind,
    input  prbe_pkg::t_pri    i_new_priority,
    input  prbe_pkg::t_id     i_new_id,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_taken_valid,
    output prbe_pkg::t_id     o_taken_id,
    output prbe_pkg::t_pri    o_taken_priority,
    output logic              o_evicted_valid,
    output prbe_pkg::t_id     o_evicted_id,
    output prbe_pkg::t_pri    o_evicted_priority,
    output prbe_pkg::t_slot   o_slot_index,
    output logic              o_now_empty
);
    import prbe_pkg::*;

    localparam t_pri PRI_MAX = t_pri'(PRIORITY_LEVELS - 1);

    // Slot storage
    logic [SLOTS-1:0] r_used;
    t_pri             r_slot_pri [SLOTS];
    t_id              r_slot_id  [SLOTS];
    t_slot            r_ptr;
    t_count           r_occ;

    // Item in flight and scan state
    logic  r_kind;
    t_pri  r_pri;
    t_id   r_id;
    t_slot r_idx;
    t_slot r_cnt;
    logic  r_evict;
    logic  r_have;
    t_pri  r_best_pri;
    t_id   r_best_id;
    t_slot r_best_idx;

    // Result register
    logic  r_out_valid;
    logic  r_taken_valid;
    t_id   r_taken_id;
    t_pri  r_taken_pri;
    logic  r_ev_valid;
    t_id   r_ev_id;
    t_pri  r_ev_pri;
    t_slot r_slot_out;
    logic  r_empty;

    // Slot under scan
    t_pri  rd_pri;
    t_id   rd_id;
    logic  rd_used;
    logic  better;

    assign rd_pri  = r_slot_pri[r_idx];
    assign rd_id   = r_slot_id[r_idx];
    assign rd_used = r_used[r_idx];

    // Strict compare keeps the lowest index on full ties
    assign better = rd_used && (!r_have || (rd_pri < r_best_pri) ||
                    ((rd_pri == r_best_pri) && (rd_id < r_best_id)));

    assign o_status.kind      = r_kind;
    assign o_status.slot_free = !rd_used;
    assign o_status.last      = (r_cnt == t_slot'(SLOTS - 1));
    assign o_status.out_busy  = r_out_valid;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_ptr       <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (r_kind == KIND_INSERT) begin
                    r_used[r_idx] <= 1'b1;
                    r_ptr         <= next_slot(r_idx);
                    if (!r_evict) begin
                        r_occ <= r_occ + t_count'(1);
                    end
                end else if (r_have) begin
                    r_used[r_best_idx] <= 1'b0;
                    r_occ              <= r_occ - t_count'(1);
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Scan and payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind  <= i_kind;
            r_pri   <= (i_new_priority > PRI_MAX) ? PRI_MAX : i_new_priority;
            r_id    <= i_new_id;
            r_idx   <= (i_kind == KIND_INSERT) ? r_ptr : '0;
            r_cnt   <= '0;
            r_evict <= 1'b0;
            r_have  <= 1'b0;
        end
        if (i_cmd.ins_step) begin
            r_idx <= next_slot(r_idx);
            r_cnt <= r_cnt + t_slot'(1);
        end
        if (i_cmd.ins_evict) begin
            r_evict <= 1'b1;
        end
        if (i_cmd.take_step) begin
            if (better) begin
                r_have     <= 1'b1;
                r_best_pri <= rd_pri;
                r_best_id  <= rd_id;
                r_best_idx <= r_idx;
            end
            r_idx <= next_slot(r_idx);
            r_cnt <= r_cnt + t_slot'(1);
        end
        if (i_cmd.commit) begin
            if (r_kind == KIND_INSERT) begin
                r_slot_pri[r_idx] <= r_pri;
                r_slot_id[r_idx]  <= r_id;
                r_taken_valid     <= 1'b0;
                r_taken_id        <= '0;
                r_taken_pri       <= '0;
                r_ev_valid        <= r_evict;
                r_ev_id           <= r_evict ? rd_id : '0;
                r_ev_pri          <= r_evict ? rd_pri : '0;
                r_slot_out        <= r_idx;
                r_empty           <= 1'b0;
            end else begin
                r_taken_valid     <= r_have;
                r_taken_id        <= r_have ? r_best_id : '0;
                r_taken_pri       <= r_have ? r_best_pri : '0;
                r_ev_valid        <= 1'b0;
                r_ev_id           <= '0;
                r_ev_pri          <= '0;
                r_slot_out        <= r_have ? r_best_idx : '0;
                r_empty           <= !r_have || (r_occ == t_count'(1));
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_taken_valid      = r_taken_valid;
    assign o_taken_id         = r_taken_id;
    assign o_taken_priority   = r_taken_pri;
    assign o_evicted_valid    = r_ev_valid;
    assign o_evicted_id       = r_ev_id;
    assign o_evicted_priority = r_ev_pri;
    assign o_slot_index       = r_slot_out;
    assign o_now_empty        = r_empty;

endmodule

@@ rtl/priority_ring_buffer_with_eviction.sv @@
`timescale 1ns / 1ps
// Insert scans the ring one slot per cycle from the insert pointer (ring scan) and
//   stops at the first free slot; take scans every slot.
// Flow: one item at a time; next item accepted the cycle after commit.
// Reset: synchronous active low; empties all slots, clears pointer and count.
module priority_ring_buffer_with_eviction (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_kind,
    input  prbe_pkg::t_pri  i_new_priority,
    input  prbe_pkg::t_id   i_new_id,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_taken_valid,
    output prbe_pkg::t_id   o_taken_id,
    output prbe_pkg::t_pri  o_taken_priority,
    output logic            o_evicted_valid,
    output prbe_pkg::t_id   o_evicted_id,
    output prbe_pkg::t_pri  o_evicted_priority,
    output prbe_pkg::t_slot o_slot_index,
    output logic            o_now_empty
);
    import prbe_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer
    prbe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Slot storage, scan and result register
    prbe_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_kind             (i_kind),
        .i_new_priority     (i_new_priority),
        .i_new_id           (i_new_id),
        .i_ready            (i_ready),
        .o_valid            (o_valid),
        .o_taken_valid      (o_taken_valid),
        .o_taken_id         (o_taken_id),
        .o_taken_priority   (o_taken_priority),
        .o_evicted_valid    (o_evicted_valid),
        .o_evicted_id       (o_evicted_id),
        .o_evicted_priority (o_evicted_priority),
        .o_slot_index       (o_slot_index),
        .o_now_empty        (o_now_empty)
    );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import prbe_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT_ITEM = 400;

    // One result item as the block reports it
    typedef struct packed {
        logic taken_valid;
        t_id  taken_id;
        t_pri taken_priority;
        logic evicted_valid;
        t_id  evicted_id;
        t_pri evicted_priority;
        t_slot slot_index;
        logic now_empty;
    } t_slot_report;

    // One row of stimulus; a typed report is used instead of the shadow one
    typedef struct {
        logic         kind;
        t_pri         pri;
        t_id          id;
        bit           has_typed;
        t_slot_report typed;
    } t_request_row;

    typedef enum int {RX_STEADY, RX_MOSTLY, RX_TOGGLE, RX_SPARSE} t_rx_mode;

    logic  i_clk          = 1'b0;
    logic  i_rst_n        = 1'b0;
    logic  i_valid        = 1'b0;
    logic  i_kind         = KIND_INSERT;
    t_pri  i_new_priority = '0;
    t_id   i_new_id       = '0;
    logic  i_ready        = 1'b0;
    logic  o_ready;
    logic  o_valid;
    logic  o_taken_valid;
    t_id   o_taken_id;
    t_pri  o_taken_priority;
    logic  o_evicted_valid;
    t_id   o_evicted_id;
    t_pri  o_evicted_priority;
    t_slot o_slot_index;
    logic  o_now_empty;

    t_request_row request_rows[$];
    t_slot_report predicted_reports[$];
    int           accept_idx = 0;
    int           mismatches = 0;
    int           cycle_count = 0;

    // Shadow copy of the buffer
    bit    shadow_used[SLOTS];
    t_pri  shadow_pri[SLOTS];
    t_id   shadow_id[SLOTS];
    t_slot shadow_ptr = '0;
    int    shadow_occ = 0;

    priority_ring_buffer_with_eviction i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_kind             (i_kind),
        .i_new_priority     (i_new_priority),
        .i_new_id           (i_new_id),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_taken_valid      (o_taken_valid),
        .o_taken_id         (o_taken_id),
        .o_taken_priority   (o_taken_priority),
        .o_evicted_valid    (o_evicted_valid),
        .o_evicted_id       (o_evicted_id),
        .o_evicted_priority (o_evicted_priority),
        .o_slot_index       (o_slot_index),
        .o_now_empty        (o_now_empty)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Ring insert / lowest-priority take on the shadow buffer
    function automatic t_slot_report advance_shadow_buffer(logic kind, t_pri pri, t_id id);
        t_slot_report r;
        t_slot        s;
        t_slot        place;
        int           best;
        bit           found;
        bit           have;
        r = '0;
        if (kind == KIND_INSERT) begin
            place = shadow_ptr;
            found = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                s = t_slot'((shadow_ptr + i) % SLOTS);
                if (!found && !shadow_used[s]) begin
                    place = s;
                    found = 1'b1;
                end
            end
            // full: the entry at the pointer goes out
            if (!found) begin
                r.evicted_valid    = 1'b1;
                r.evicted_id       = shadow_id[place];
                r.evicted_priority = shadow_pri[place];
                shadow_occ--;
            end
            shadow_used[place] = 1'b1;
            shadow_pri[place]  = pri;
            shadow_id[place]   = id;
            shadow_occ++;
            shadow_ptr   = t_slot'((place + 1) % SLOTS);
            r.slot_index = place;
        end else begin
            have = 1'b0;
            best = 0;
            // strict compares keep the lowest index on full ties
            for (int i = 0; i < SLOTS; i++) begin
                if (shadow_used[i] && (!have || shadow_pri[i] < shadow_pri[best] ||
                    (shadow_pri[i] == shadow_pri[best] && shadow_id[i] < shadow_id[best]))) begin
                    best = i;
                    have = 1'b1;
                end
            end
            if (have) begin
                r.taken_valid    = 1'b1;
                r.taken_id       = shadow_id[best];
                r.taken_priority = shadow_pri[best];
                r.slot_index     = t_slot'(best);
                shadow_used[best] = 1'b0;
                shadow_occ--;
            end
        end
        r.now_empty = (shadow_occ == 0);
        return r;
    endfunction

    task automatic note_mismatch(string what, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0h, got %0h (item %0d)", what, want, got,
                     accept_idx);
    endtask

    task automatic add_row(logic kind, t_pri pri, t_id id);
        t_request_row row;
        row.kind      = kind;
        row.pri       = pri;
        row.id        = id;
        row.has_typed = 1'b0;
        row.typed     = '0;
        request_rows.push_back(row);
    endtask

    task automatic add_typed_row(logic kind, t_pri pri, t_id id, t_slot_report rep);
        t_request_row row;
        row.kind      = kind;
        row.pri       = pri;
        row.id        = id;
        row.has_typed = 1'b1;
        row.typed     = rep;
        request_rows.push_back(row);
    endtask

    // Result checking and prediction on accepted items
    always @(posedge i_clk) begin : scoreboard
        t_slot_report got;
        t_slot_report want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got.taken_valid      = o_taken_valid;
                got.taken_id         = o_taken_id;
                got.taken_priority   = o_taken_priority;
                got.evicted_valid    = o_evicted_valid;
                got.evicted_id       = o_evicted_id;
                got.evicted_priority = o_evicted_priority;
                got.slot_index       = o_slot_index;
                got.now_empty        = o_now_empty;
                if (predicted_reports.size() == 0) begin
                    note_mismatch("unexpected result", 0, 32'(got));
                end else begin
                    want = predicted_reports.pop_front();
                    if (got.taken_valid !== want.taken_valid)
                        note_mismatch("taken_valid", 32'(want.taken_valid),
                                      32'(got.taken_valid));
                    if (got.taken_id !== want.taken_id)
                        note_mismatch("taken_id", 32'(want.taken_id), 32'(got.taken_id));
                    if (got.taken_priority !== want.taken_priority)
                        note_mismatch("taken_priority", 32'(want.taken_priority),
                                      32'(got.taken_priority));
                    if (got.evicted_valid !== want.evicted_valid)
                        note_mismatch("evicted_valid", 32'(want.evicted_valid),
                                      32'(got.evicted_valid));
                    if (got.evicted_id !== want.evicted_id)
                        note_mismatch("evicted_id", 32'(want.evicted_id),
                                      32'(got.evicted_id));
                    if (got.evicted_priority !== want.evicted_priority)
                        note_mismatch("evicted_priority", 32'(want.evicted_priority),
                                      32'(got.evicted_priority));
                    if (got.slot_index !== want.slot_index)
                        note_mismatch("slot_index", 32'(want.slot_index),
                                      32'(got.slot_index));
                    if (got.now_empty !== want.now_empty)
                        note_mismatch("now_empty", 32'(want.now_empty), 32'(got.now_empty));
                end
            end
            if (i_valid && o_ready) begin
                want = advance_shadow_buffer(i_kind, i_new_priority, i_new_id);
                if (accept_idx < request_rows.size() && request_rows[accept_idx].has_typed)
                    want = request_rows[accept_idx].typed;
                predicted_reports.push_back(want);
                accept_idx++;
            end
        end
    end

    // Receiver: ready pattern of its own, one long hold-off to fill the block
    initial begin : receiver
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        bit       hold_done;
        mode      = RX_STEADY;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (!hold_done && accept_idx >= HOLD_AT_ITEM) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    i_ready <= 1'b0;
                end else begin
                    if (mode_left == 0) begin
                        mode      = t_rx_mode'($urandom_range(0, 3));
                        mode_left = $urandom_range(5, 60);
                    end
                    mode_left--;
                    case (mode)
                        RX_STEADY: i_ready <= 1'b1;
                        RX_MOSTLY: i_ready <= ($urandom_range(0, 3) != 0);
                        RX_TOGGLE: i_ready <= ~i_ready;
                        default:   i_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    // Stimulus build, reset, sender and end of run
    initial begin : main
        t_slot_report rep;
        int           produced;
        int           seg_len;
        int           insert_pct;
        int           burst_left;
        int           gap;
        t_id          id;

        // directed: empty take, extremes, tie breaks, eviction, drain to empty
        rep = '0;
        rep.now_empty = 1'b1;
        add_typed_row(KIND_TAKE, 3'd5, 16'h1234, rep);
        rep = '0;
        add_typed_row(KIND_INSERT, 3'd7, 16'hFFFF, rep);
        rep = '0;
        rep.taken_valid    = 1'b1;
        rep.taken_id       = 16'hFFFF;
        rep.taken_priority = 3'd7;
        rep.now_empty      = 1'b1;
        add_typed_row(KIND_TAKE, 3'd0, 16'h0000, rep);
        add_row(KIND_INSERT, 3'd0, 16'h0000);
        add_row(KIND_INSERT, 3'd3, 16'h0005);
        add_row(KIND_INSERT, 3'd3, 16'h0005);
        add_row(KIND_INSERT, 3'd3, 16'h0002);
        add_row(KIND_INSERT, 3'd7, 16'hFFFF);
        add_row(KIND_INSERT, 3'd0, 16'hFFFF);
        add_row(KIND_INSERT, 3'd5, 16'h0100);
        add_row(KIND_INSERT, 3'd1, 16'h0008);
        add_row(KIND_INSERT, 3'd6, 16'h1234);
        add_row(KIND_INSERT, 3'd2, 16'h0000);
        for (int i = 0; i < 9; i++)
            add_row(KIND_TAKE, t_pri'($urandom_range(0, 7)), t_id'($urandom));
        rep = '0;
        rep.now_empty = 1'b1;
        add_typed_row(KIND_TAKE, 3'd7, 16'hFFFF, rep);

        // random: segments biased to fill, drain or hover
        produced = 0;
        while (produced < RANDOM_ITEMS) begin
            seg_len = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0:       insert_pct = 85;
                1:       insert_pct = 50;
                default: insert_pct = 15;
            endcase
            for (int i = 0; i < seg_len && produced < RANDOM_ITEMS; i++) begin
                case ($urandom_range(0, 3))
                    0:       id = t_id'($urandom_range(0, 3));
                    1:       id = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    default: id = t_id'($urandom);
                endcase
                add_row(($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_TAKE,
                        t_pri'($urandom_range(0, 7)), id);
                produced++;
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (!i_rst_n);

        // sender: bursts of items with random gaps
        burst_left = 0;
        foreach (request_rows[n]) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            i_valid        <= 1'b1;
            i_kind         <= request_rows[n].kind;
            i_new_priority <= request_rows[n].pri;
            i_new_id       <= request_rows[n].id;
            do @(posedge i_clk); while (!o_ready);
        end
        i_valid <= 1'b0;

        while (accept_idx < request_rows.size() || predicted_reports.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (predicted_reports.size() > 0)
            note_mismatch("missing results", 32'(predicted_reports.size()), 0);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
